// File: rtl/multi_led_blink_controller_core_defines.svh
// Assertion macros for the multi-LED blink controller
`ifndef MULTI_LED_BLINK_CONTROLLER_CORE_DEFINES_SVH
`define MULTI_LED_BLINK_CONTROLLER_CORE_DEFINES_SVH

// same-cycle implication, held off during reset
`define MLBC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbl failed");

// next-cycle implication, held off during reset
`define MLBC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbl failed");

`endif

// File: rtl/mlbc_pkg.sv
// Shared types and constants of the multi-LED blink controller
`default_nettype none

package mlbc_pkg;

    localparam int LED_NUM    = 8;
    localparam int BOOT_LED   = 7;
    localparam int LINES_USED = (LED_NUM < 8) ? LED_NUM : 8;

    localparam int IDX_W  = 4;
    localparam int IND_W  = 3;
    localparam int ADDR_W = 5;

    localparam logic [15:0] RESET_INTERVAL = 16'd500;
    localparam logic [15:0] RESET_SCAN     = 16'd50;
    localparam logic [15:0] RESET_SHORT    = 16'd600;
    localparam logic [15:0] RESET_LONG     = 16'd1800;
    localparam logic [2:0]  RESET_SHORT_LED = 3'd2;
    localparam logic [2:0]  RESET_MID_LED   = 3'd3;
    localparam logic [2:0]  RESET_LONG_LED  = 3'd4;

    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_SET_MODE = 2'd1;
    localparam logic [1:0] OP_TIME_SEL = 2'd2;
    localparam logic [1:0] OP_READ     = 2'd3;

    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_ON    = 2'd1;
    localparam logic [1:0] MODE_BLINK = 2'd2;

    localparam logic [2:0] REG_SCAN_PERIOD = 3'd0;
    localparam logic [2:0] REG_DEF_INTV    = 3'd1;
    localparam logic [2:0] REG_SHORT_LIM   = 3'd2;
    localparam logic [2:0] REG_LONG_LIM    = 3'd3;
    localparam logic [2:0] REG_SHORT_LED   = 3'd4;
    localparam logic [2:0] REG_MID_LED     = 3'd5;
    localparam logic [2:0] REG_LONG_LED    = 3'd6;

    typedef struct packed {
        logic [15:0]      scan_period;
        logic [15:0]      default_interval;
        logic [15:0]      short_limit;
        logic [15:0]      long_limit;
        logic [IND_W-1:0] short_led;
        logic [IND_W-1:0] mid_led;
        logic [IND_W-1:0] long_led;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } cmd_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } ctrl_state_t;

endpackage

`default_nettype wire

// File: rtl/mlbc_regs.sv
// Configuration register file behind the APB-style port
`default_nettype none

module mlbc_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mlbc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output mlbc_pkg::cfg_t                   cfg
);

    mlbc_pkg::cfg_t cfg_reg;
    mlbc_pkg::cfg_t cfg_next;
    logic           wr_en;

    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[4:2])
                mlbc_pkg::REG_SCAN_PERIOD: cfg_next.scan_period      = pwdata[15:0];
                mlbc_pkg::REG_DEF_INTV:    cfg_next.default_interval = pwdata[15:0];
                mlbc_pkg::REG_SHORT_LIM:   cfg_next.short_limit      = pwdata[15:0];
                mlbc_pkg::REG_LONG_LIM:    cfg_next.long_limit       = pwdata[15:0];
                mlbc_pkg::REG_SHORT_LED:   cfg_next.short_led = pwdata[mlbc_pkg::IND_W-1:0];
                mlbc_pkg::REG_MID_LED:     cfg_next.mid_led   = pwdata[mlbc_pkg::IND_W-1:0];
                mlbc_pkg::REG_LONG_LED:    cfg_next.long_led  = pwdata[mlbc_pkg::IND_W-1:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            mlbc_pkg::REG_SCAN_PERIOD: prdata = {16'd0, cfg_reg.scan_period};
            mlbc_pkg::REG_DEF_INTV:    prdata = {16'd0, cfg_reg.default_interval};
            mlbc_pkg::REG_SHORT_LIM:   prdata = {16'd0, cfg_reg.short_limit};
            mlbc_pkg::REG_LONG_LIM:    prdata = {16'd0, cfg_reg.long_limit};
            mlbc_pkg::REG_SHORT_LED:   prdata = 32'(cfg_reg.short_led);
            mlbc_pkg::REG_MID_LED:     prdata = 32'(cfg_reg.mid_led);
            mlbc_pkg::REG_LONG_LED:    prdata = 32'(cfg_reg.long_led);
            default:                   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scan_period      <= mlbc_pkg::RESET_SCAN;
            cfg_reg.default_interval <= mlbc_pkg::RESET_INTERVAL;
            cfg_reg.short_limit      <= mlbc_pkg::RESET_SHORT;
            cfg_reg.long_limit       <= mlbc_pkg::RESET_LONG;
            cfg_reg.short_led        <= mlbc_pkg::RESET_SHORT_LED;
            cfg_reg.mid_led          <= mlbc_pkg::RESET_MID_LED;
            cfg_reg.long_led         <= mlbc_pkg::RESET_LONG_LED;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/mlbc_ctrl.sv
// Controller state machine: input capture, execution and result beat handshake
`default_nettype none

module mlbc_ctrl (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    output mlbc_pkg::cmd_t   cmd
);

    mlbc_pkg::ctrl_state_t state_reg;
    mlbc_pkg::ctrl_state_t state_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mlbc_pkg::S_IDLE:
            begin
                if (in_valid)
                    state_next = mlbc_pkg::S_EXEC;
            end
            mlbc_pkg::S_EXEC:
            begin
                if (out_free)
                    state_next = mlbc_pkg::S_IDLE;
            end
            default: state_next = mlbc_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        unique case (state_reg)
            mlbc_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            mlbc_pkg::S_EXEC:
            begin
                cmd.execute = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.execute)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mlbc_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/mlbc_dpath.sv
// Datapath: LED state, time counter, parallel deadline scan and result register
`default_nettype none

module mlbc_dpath (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire mlbc_pkg::cmd_t             cmd,
    input  wire mlbc_pkg::cfg_t             cfg,
    input  wire logic [1:0]                 opcode,
    input  wire logic [mlbc_pkg::IDX_W-1:0] led_id,
    input  wire logic [1:0]                 mode,
    input  wire logic [15:0]                blink_interval,
    input  wire logic [15:0]                seconds,
    output logic [7:0]                      led_lines,
    output logic                            read_value
);

    localparam int N = mlbc_pkg::LED_NUM;

    logic [1:0]                 opcode_reg;
    logic [mlbc_pkg::IDX_W-1:0] led_id_reg;
    logic [1:0]                 mode_reg;
    logic [15:0]                blink_interval_reg;
    logic [15:0]                seconds_reg;

    logic [31:0] now_reg;
    logic [31:0] now_inc_reg;
    logic [15:0] scan_reg;
    logic [15:0] scan_inc;
    logic        scan_hit;

    logic [1:0]  led_mode_reg     [N];
    logic [1:0]  led_mode_next    [N];
    logic [15:0] led_interval_reg [N];
    logic [15:0] led_interval_next[N];
    logic [31:0] next_toggle_reg  [N];
    logic [31:0] next_toggle_next [N];
    logic [N-1:0] led_on_reg;
    logic [N-1:0] led_on_next;
    logic [31:0] late             [N];

    logic [15:0]                start_intv;
    logic [mlbc_pkg::IDX_W-1:0] short_idx;
    logic [mlbc_pkg::IDX_W-1:0] mid_idx;
    logic [mlbc_pkg::IDX_W-1:0] long_idx;
    logic [mlbc_pkg::IDX_W-1:0] sel_idx;
    logic                       sel_valid;
    logic                       read_hit;
    logic [7:0]                 lines;
    logic [7:0]                 led_lines_reg;
    logic                       read_value_reg;

    assign scan_inc   = scan_reg + 16'd1;
    assign scan_hit   = scan_inc >= cfg.scan_period;
    assign start_intv = (blink_interval_reg != 16'd0) ? blink_interval_reg
                                                     : cfg.default_interval;
    assign short_idx  = mlbc_pkg::IDX_W'(cfg.short_led);
    assign mid_idx    = mlbc_pkg::IDX_W'(cfg.mid_led);
    assign long_idx   = mlbc_pkg::IDX_W'(cfg.long_led);
    assign sel_valid  = seconds_reg != 16'd0;
    assign led_lines  = led_lines_reg;
    assign read_value = read_value_reg;

    always_comb
    begin
        if (seconds_reg > cfg.long_limit)
            sel_idx = long_idx;
        else if (seconds_reg > cfg.short_limit)
            sel_idx = mid_idx;
        else
            sel_idx = short_idx;
    end

    always_comb
    begin
        read_hit = 1'b0;
        for (int i = 0; i < N; i++)
        begin
            late[i]              = now_inc_reg - next_toggle_reg[i];
            led_mode_next[i]     = led_mode_reg[i];
            led_interval_next[i] = led_interval_reg[i];
            next_toggle_next[i]  = next_toggle_reg[i];
            led_on_next[i]       = led_on_reg[i];
            if (led_id_reg == mlbc_pkg::IDX_W'(i) && led_on_reg[i])
                read_hit = 1'b1;
            unique case (opcode_reg)
                mlbc_pkg::OP_TICK:
                begin
                    if (scan_hit && led_mode_reg[i] == mlbc_pkg::MODE_BLINK && !late[i][31])
                    begin
                        led_on_next[i]      = !led_on_reg[i];
                        next_toggle_next[i] = now_inc_reg + 32'(led_interval_reg[i]);
                    end
                end
                mlbc_pkg::OP_SET_MODE:
                begin
                    if (led_id_reg == mlbc_pkg::IDX_W'(i))
                    begin
                        led_mode_next[i] = mode_reg;
                        if (mode_reg == mlbc_pkg::MODE_BLINK)
                        begin
                            led_interval_next[i] = start_intv;
                            next_toggle_next[i]  = now_reg + 32'(start_intv);
                            led_on_next[i]       = 1'b1;
                        end
                        else
                        begin
                            led_on_next[i] = (mode_reg == mlbc_pkg::MODE_ON);
                        end
                    end
                end
                mlbc_pkg::OP_TIME_SEL:
                begin
                    if (short_idx == mlbc_pkg::IDX_W'(i) || mid_idx == mlbc_pkg::IDX_W'(i)
                        || long_idx == mlbc_pkg::IDX_W'(i))
                    begin
                        led_mode_next[i] = mlbc_pkg::MODE_OFF;
                        led_on_next[i]   = 1'b0;
                    end
                    if (sel_valid && sel_idx == mlbc_pkg::IDX_W'(i))
                    begin
                        led_mode_next[i] = mlbc_pkg::MODE_ON;
                        led_on_next[i]   = 1'b1;
                    end
                end
                default:
                begin
                    led_on_next[i] = led_on_reg[i];
                end
            endcase
        end
    end

    always_comb
    begin
        lines = 8'd0;
        for (int i = 0; i < mlbc_pkg::LINES_USED; i++)
            lines[i] = led_on_next[i];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            opcode_reg         <= opcode;
            led_id_reg         <= led_id;
            mode_reg           <= mode;
            blink_interval_reg <= blink_interval;
            seconds_reg        <= seconds;
        end
        if (cmd.execute)
        begin
            led_lines_reg  <= lines;
            read_value_reg <= (opcode_reg == mlbc_pkg::OP_READ) && read_hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg     <= 32'd0;
            now_inc_reg <= 32'd1;
            scan_reg    <= 16'd0;
            for (int i = 0; i < N; i++)
            begin
                led_mode_reg[i]     <= (i == mlbc_pkg::BOOT_LED) ? mlbc_pkg::MODE_ON
                                                                 : mlbc_pkg::MODE_OFF;
                led_interval_reg[i] <= mlbc_pkg::RESET_INTERVAL;
                next_toggle_reg[i]  <= 32'd0;
                led_on_reg[i]       <= (i == mlbc_pkg::BOOT_LED);
            end
        end
        else if (cmd.execute)
        begin
            if (opcode_reg == mlbc_pkg::OP_TICK)
            begin
                now_reg     <= now_inc_reg;
                now_inc_reg <= now_inc_reg + 32'd1;
                scan_reg    <= scan_hit ? 16'd0 : scan_inc;
            end
            for (int i = 0; i < N; i++)
            begin
                led_mode_reg[i]     <= led_mode_next[i];
                led_interval_reg[i] <= led_interval_next[i];
                next_toggle_reg[i]  <= next_toggle_next[i];
            end
            led_on_reg <= led_on_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/multi_led_blink_controller_core.sv
// Top level of the multi-LED blink controller
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------------------
//   input    | in_valid / in_ready    | opcode, led_id, mode, blink_interval, seconds
//   result   | out_valid / out_ready  | led_lines, read_value
//   config   | psel, penable, pwrite  | paddr, pwdata, prdata (pready tied high)
//
// Each item is first captured from the beat, then executed, updating all LEDs at once.
// The execute cycle waits while an earlier result beat is still held by out_ready low.
// A new beat is taken as soon as the previous item has executed.
// Reset clears control state and loads the boot LED as lit; no clearing pass is needed.
`default_nettype none
`include "multi_led_blink_controller_core_defines.svh"

module multi_led_blink_controller_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [1:0]                  opcode,
    input  wire logic [mlbc_pkg::IDX_W-1:0]  led_id,
    input  wire logic [1:0]                  mode,
    input  wire logic [15:0]                 blink_interval,
    input  wire logic [15:0]                 seconds,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [7:0]                       led_lines,
    output logic                             read_value,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mlbc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    mlbc_pkg::cfg_t cfg;
    mlbc_pkg::cmd_t cmd;

    assign pready = 1'b1;

    mlbc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    mlbc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    mlbc_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg            (cfg),
        .opcode         (opcode),
        .led_id         (led_id),
        .mode           (mode),
        .blink_interval (blink_interval),
        .seconds        (seconds),
        .led_lines      (led_lines),
        .read_value     (read_value)
    );

    `MLBC_ASSERT_NEXT(a_accept_then_busy, in_valid && in_ready, !in_ready)
    `MLBC_ASSERT_NOW(a_exec_needs_room, cmd.execute, !out_valid || out_ready)
    `MLBC_ASSERT_NOW(a_result_from_exec, $rose(out_valid), $past(cmd.execute))
    `MLBC_ASSERT_NEXT(a_exec_then_result, cmd.execute, out_valid)

endmodule

`default_nettype wire

// File: verif/tb_multi_led_blink_controller_core.sv
// Self-checking testbench for the multi-LED blink controller: predicts every result beat.
module tb_multi_led_blink_controller_core;

    localparam logic [1:0] MODE_DARK   = 2'd3;
    localparam int         CYCLE_LIMIT = 300000;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        in_valid       = 1'b0;
    logic [1:0]  opcode         = '0;
    logic [3:0]  led_id         = '0;
    logic [1:0]  mode           = '0;
    logic [15:0] blink_interval = '0;
    logic [15:0] seconds        = '0;
    logic        out_ready      = 1'b0;
    logic        psel           = 1'b0;
    logic        penable        = 1'b0;
    logic        pwrite         = 1'b0;
    logic [4:0]  paddr          = '0;
    logic [31:0] pwdata         = '0;
    logic        in_ready;
    logic        out_valid;
    logic [7:0]  led_lines;
    logic        read_value;
    logic [31:0] prdata;
    logic        pready;

    int send_gap_pct = 34;
    int recv_gap_pct = 78;
    int hold_request = 0;
    int cycle_count  = 0;

    class led_state_tracker;
        mlbc_pkg::cfg_t cfg;
        logic [1:0]  led_mode[mlbc_pkg::LED_NUM];
        logic [15:0] led_gap[mlbc_pkg::LED_NUM];
        logic [31:0] due_ms[mlbc_pkg::LED_NUM];
        logic        lit[mlbc_pkg::LED_NUM];
        logic [31:0] now_ms;
        logic [15:0] ticks_since_scan;
        logic [7:0]  lines_due[$];
        logic        read_due[$];
        int          errors;

        function new();
            int i;
            cfg.scan_period      = mlbc_pkg::RESET_SCAN;
            cfg.default_interval = mlbc_pkg::RESET_INTERVAL;
            cfg.short_limit      = mlbc_pkg::RESET_SHORT;
            cfg.long_limit       = mlbc_pkg::RESET_LONG;
            cfg.short_led        = mlbc_pkg::RESET_SHORT_LED;
            cfg.mid_led          = mlbc_pkg::RESET_MID_LED;
            cfg.long_led         = mlbc_pkg::RESET_LONG_LED;
            for (i = 0; i < mlbc_pkg::LED_NUM; i++)
            begin
                led_mode[i] = mlbc_pkg::MODE_OFF;
                led_gap[i]  = mlbc_pkg::RESET_INTERVAL;
                due_ms[i]   = '0;
                lit[i]      = 1'b0;
            end
            now_ms           = '0;
            ticks_since_scan = '0;
            errors           = 0;
            set_led(mlbc_pkg::BOOT_LED, mlbc_pkg::MODE_ON, 16'd0);
        endfunction

        function void set_led(int idx, logic [1:0] md, logic [15:0] intv);
            if (idx >= mlbc_pkg::LED_NUM)
                return;
            led_mode[idx] = md;
            if (md == mlbc_pkg::MODE_BLINK)
            begin
                led_gap[idx] = (intv != 16'd0) ? intv : cfg.default_interval;
                due_ms[idx]  = now_ms + {16'd0, led_gap[idx]};
                lit[idx]     = 1'b1;
            end
            else if (md == mlbc_pkg::MODE_ON)
                lit[idx] = 1'b1;
            else
                lit[idx] = 1'b0;
        endfunction

        function void advance_clock();
            logic [31:0] late;
            int          i;
            now_ms           = now_ms + 32'd1;
            ticks_since_scan = ticks_since_scan + 16'd1;
            if (ticks_since_scan >= cfg.scan_period)
            begin
                ticks_since_scan = '0;
                for (i = 0; i < mlbc_pkg::LED_NUM; i++)
                begin
                    late = now_ms - due_ms[i];
                    if (led_mode[i] == mlbc_pkg::MODE_BLINK && !late[31])
                    begin
                        lit[i]    = ~lit[i];
                        due_ms[i] = now_ms + {16'd0, led_gap[i]};
                    end
                end
            end
        endfunction

        function void select_indicator(logic [15:0] secs);
            set_led(int'(cfg.short_led), mlbc_pkg::MODE_OFF, 16'd0);
            set_led(int'(cfg.mid_led), mlbc_pkg::MODE_OFF, 16'd0);
            set_led(int'(cfg.long_led), mlbc_pkg::MODE_OFF, 16'd0);
            if (secs == 16'd0)
                return;
            if (secs > cfg.long_limit)
                set_led(int'(cfg.long_led), mlbc_pkg::MODE_ON, 16'd0);
            else if (secs > cfg.short_limit)
                set_led(int'(cfg.mid_led), mlbc_pkg::MODE_ON, 16'd0);
            else
                set_led(int'(cfg.short_led), mlbc_pkg::MODE_ON, 16'd0);
        endfunction

        function void load_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                mlbc_pkg::REG_SCAN_PERIOD: cfg.scan_period      = value[15:0];
                mlbc_pkg::REG_DEF_INTV:    cfg.default_interval = value[15:0];
                mlbc_pkg::REG_SHORT_LIM:   cfg.short_limit      = value[15:0];
                mlbc_pkg::REG_LONG_LIM:    cfg.long_limit       = value[15:0];
                mlbc_pkg::REG_SHORT_LED:   cfg.short_led        = value[2:0];
                mlbc_pkg::REG_MID_LED:     cfg.mid_led          = value[2:0];
                mlbc_pkg::REG_LONG_LED:    cfg.long_led         = value[2:0];
                default: ;
            endcase
        endfunction

        function void note_item(logic [1:0] op, logic [3:0] idx, logic [1:0] md,
                                logic [15:0] intv, logic [15:0] secs);
            logic [7:0] lines;
            logic       level;
            int         i;
            level = 1'b0;
            lines = '0;
            case (op)
                mlbc_pkg::OP_TICK:     advance_clock();
                mlbc_pkg::OP_SET_MODE: set_led(int'(idx), md, intv);
                mlbc_pkg::OP_TIME_SEL: select_indicator(secs);
                default:
                begin
                    if (int'(idx) < mlbc_pkg::LED_NUM)
                        level = lit[idx];
                end
            endcase
            for (i = 0; i < mlbc_pkg::LED_NUM && i < 8; i++)
                lines[i] = lit[i];
            lines_due.push_back(lines);
            read_due.push_back(level);
        endfunction

        function void check_result(logic [7:0] lines, logic level);
            logic [7:0] want_lines;
            logic       want_level;
            if (lines_due.size() == 0)
            begin
                $error("led_lines: beat with nothing outstanding, expected none, got %h", lines);
                errors++;
                return;
            end
            want_lines = lines_due.pop_front();
            want_level = read_due.pop_front();
            if (lines !== want_lines)
            begin
                $error("led_lines: expected %h, got %h", want_lines, lines);
                errors++;
            end
            if (level !== want_level)
            begin
                $error("read_value: expected %b, got %b", want_level, level);
                errors++;
            end
        endfunction

        function int pending();
            return lines_due.size();
        endfunction
    endclass

    led_state_tracker leds = new();

    multi_led_blink_controller_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .led_id         (led_id),
        .mode           (mode),
        .blink_interval (blink_interval),
        .seconds        (seconds),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .led_lines      (led_lines),
        .read_value     (read_value),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("multi_led_blink_controller_core: mismatch");
            $finish;
        end
    end

    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                leds.check_result(led_lines, read_value);
            if (hold_request > 0)
            begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [3:0] idx, input logic [1:0] md,
                             input logic [15:0] intv, input logic [15:0] secs);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        opcode         <= op;
        led_id         <= idx;
        mode           <= md;
        blink_interval <= intv;
        seconds        <= secs;
        do @(posedge clk); while (!in_ready);
        leds.note_item(op, idx, md, intv, secs);
    endtask

    task automatic await_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (leds.pending() != 0);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        leds.load_reg(idx, value);
    endtask

    task automatic program_regs(input logic [15:0] sp, input logic [15:0] di,
                                input logic [15:0] sl, input logic [15:0] ll,
                                input logic [2:0] sled, input logic [2:0] mled,
                                input logic [2:0] lled);
        logic [31:0] noise;
        noise = $urandom();
        write_reg(mlbc_pkg::REG_SCAN_PERIOD, {noise[31:16], sp});
        write_reg(mlbc_pkg::REG_DEF_INTV, {noise[15:0], di});
        write_reg(mlbc_pkg::REG_SHORT_LIM, {noise[23:8], sl});
        write_reg(mlbc_pkg::REG_LONG_LIM, {noise[27:12], ll});
        write_reg(mlbc_pkg::REG_SHORT_LED, {noise[28:0], sled});
        write_reg(mlbc_pkg::REG_MID_LED, {noise[31:3], mled});
        write_reg(mlbc_pkg::REG_LONG_LED, {noise[30:2], lled});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_random(input int count, input int pause_at);
        logic [1:0]  op;
        logic [1:0]  md;
        logic [3:0]  idx;
        logic [15:0] intv;
        logic [15:0] secs;
        int          r;
        int          n;
        for (n = 0; n < count; n++)
        begin
            if (n == pause_at)
                await_results();
            r    = int'($urandom_range(99));
            op   = (r < 50) ? mlbc_pkg::OP_TICK : (r < 72) ? mlbc_pkg::OP_SET_MODE :
                   (r < 85) ? mlbc_pkg::OP_TIME_SEL : mlbc_pkg::OP_READ;
            idx  = 4'($urandom());
            md   = 2'($urandom());
            intv = 16'($urandom());
            secs = 16'($urandom());
            if ($urandom_range(9) != 0)
                idx = 4'($urandom_range(mlbc_pkg::LED_NUM - 1));
            if ($urandom_range(99) < 45)
                md = mlbc_pkg::MODE_BLINK;
            r = int'($urandom_range(99));
            if (r < 15)
                intv = '0;
            else if (r >= 30)
                intv = 16'($urandom_range(40, 1));
            r = int'($urandom_range(99));
            if (r < 10)
                secs = '0;
            else if (r < 35)
                secs = 16'(leds.cfg.short_limit + $urandom_range(2) - 1);
            else if (r < 60)
                secs = 16'(leds.cfg.long_limit + $urandom_range(2) - 1);
            send_item(op, idx, md, intv, secs);
        end
    endtask

    initial
    begin
        int phase;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(mlbc_pkg::OP_READ, 4'd7, mlbc_pkg::MODE_OFF, 16'd0, 16'd0);
        send_item(mlbc_pkg::OP_READ, 4'd15, mlbc_pkg::MODE_ON, 16'hFFFF, 16'hFFFF);
        send_item(mlbc_pkg::OP_READ, 4'd0, mlbc_pkg::MODE_OFF, 16'd0, 16'd0);
        send_item(mlbc_pkg::OP_SET_MODE, 4'd0, mlbc_pkg::MODE_ON, 16'd0, 16'd0);
        send_item(mlbc_pkg::OP_SET_MODE, 4'd1, mlbc_pkg::MODE_BLINK, 16'd0, 16'd0);
        send_item(mlbc_pkg::OP_SET_MODE, 4'd2, mlbc_pkg::MODE_BLINK, 16'hFFFF, 16'd0);
        send_item(mlbc_pkg::OP_SET_MODE, 4'd15, mlbc_pkg::MODE_ON, 16'd3, 16'd0);
        send_item(mlbc_pkg::OP_SET_MODE, 4'd8, mlbc_pkg::MODE_BLINK, 16'd3, 16'd0);
        send_item(mlbc_pkg::OP_SET_MODE, 4'd7, MODE_DARK, 16'd0, 16'd0);
        send_item(mlbc_pkg::OP_SET_MODE, 4'd0, mlbc_pkg::MODE_OFF, 16'd0, 16'd0);
        send_item(mlbc_pkg::OP_TIME_SEL, 4'd0, mlbc_pkg::MODE_OFF, 16'd0, 16'd0);
        send_item(mlbc_pkg::OP_TIME_SEL, 4'd0, mlbc_pkg::MODE_OFF, 16'd0, 16'd600);
        send_item(mlbc_pkg::OP_TIME_SEL, 4'd0, mlbc_pkg::MODE_OFF, 16'd0, 16'd601);
        send_item(mlbc_pkg::OP_TIME_SEL, 4'd0, mlbc_pkg::MODE_OFF, 16'd0, 16'd1800);
        send_item(mlbc_pkg::OP_TIME_SEL, 4'd0, mlbc_pkg::MODE_OFF, 16'd0, 16'd1801);
        send_item(mlbc_pkg::OP_TIME_SEL, 4'd0, mlbc_pkg::MODE_OFF, 16'd0, 16'hFFFF);
        repeat (3) send_item(mlbc_pkg::OP_TICK, 4'd0, mlbc_pkg::MODE_OFF, 16'd0, 16'd0);
        await_results();

        // zero scan period scans on every tick; indicators share one LED
        program_regs(16'd0, 16'd1, 16'd0, 16'd0, 3'd6, 3'd6, 3'd6);
        send_item(mlbc_pkg::OP_SET_MODE, 4'd5, mlbc_pkg::MODE_BLINK, 16'd0, 16'd0);
        send_item(mlbc_pkg::OP_TICK, 4'd0, mlbc_pkg::MODE_OFF, 16'd0, 16'd0);
        send_item(mlbc_pkg::OP_TICK, 4'd0, mlbc_pkg::MODE_OFF, 16'd0, 16'd0);
        send_item(mlbc_pkg::OP_SET_MODE, 4'd3, mlbc_pkg::MODE_BLINK, 16'd3, 16'd0);
        send_item(mlbc_pkg::OP_TIME_SEL, 4'd0, mlbc_pkg::MODE_OFF, 16'd0, 16'd1);
        send_item(mlbc_pkg::OP_READ, 4'd6, mlbc_pkg::MODE_OFF, 16'd0, 16'd0);
        send_item(mlbc_pkg::OP_TIME_SEL, 4'd0, mlbc_pkg::MODE_OFF, 16'd0, 16'd0);
        send_item(mlbc_pkg::OP_READ, 4'd5, mlbc_pkg::MODE_OFF, 16'd0, 16'd0);

        for (phase = 0; phase < 7; phase++)
        begin
            await_results();
            case (phase)
                0: program_regs(16'd1, 16'd1, 16'd0, 16'hFFFF, 3'd0, 3'd7, 3'd1);
                2: program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7, 3'd7, 3'd0);
                default:
                begin
                    logic [15:0] sl;
                    sl = 16'($urandom_range(2000));
                    program_regs(16'($urandom_range(6, 1)), 16'($urandom_range(30, 1)), sl,
                                 16'(sl + $urandom_range(2000)), 3'($urandom_range(7)),
                                 3'($urandom_range(7)), 3'($urandom_range(7)));
                end
            endcase
            send_gap_pct = (phase < 2) ? 34 : (phase < 4) ? 78 : 0;
            recv_gap_pct = (phase < 2) ? 78 : (phase < 4) ? 34 : 0;
            // hold the result side off while items keep coming
            if (phase == 4)
                hold_request = 300;
            run_random(100, (phase == 5) ? 50 : -1);
        end

        await_results();
        repeat (20) @(posedge clk);
        if (leds.errors == 0)
            $display("multi_led_blink_controller_core: match");
        else
            $display("multi_led_blink_controller_core: mismatch");
        $finish;
    end

endmodule
